// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; ssdm_controller includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is held.
`define SSDM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SSDM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/ssdm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdm_pkg
// Types and constants shared by the sub-pixel SAD disparity matcher.
// ----------------------------------------------------------------------------
package ssdm_pkg;

    localparam int WINDOW_SIZE    = 9;
    localparam int MARGIN         = (WINDOW_SIZE - 1) / 2;
    localparam int RING_ROWS      = WINDOW_SIZE + 1;
    localparam int SUBPIXEL_STEPS = 8;
    localparam int SUB_LOG        = 3;
    localparam int SUB_W          = 3;
    localparam int WIN_W          = 4;
    localparam int SLOT_W         = 4;
    localparam int HEIGHT_LIMIT   = 1024;
    localparam int ROW_W          = 11;
    localparam int ROW_MAX        = 2047;
    localparam int SAD_W          = 24;
    localparam int ACC_W          = 15;
    localparam logic [SAD_W-1:0] SAD_START = 24'd10000000;
    localparam logic signed [11:0] NO_MATCH = -12'sd9;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_MIN_DISP = 2'd2;
    localparam logic [1:0] CFG_MAX_DISP = 2'd3;

    typedef struct packed {
        logic [7:0] ir_pixel;
        logic [7:0] pattern_pixel;
        logic       start_of_frame;
        logic       filler;
    } in_item_t;

    typedef struct packed {
        logic signed [11:0] disparity_eighths;
        logic [9:0]         out_row;
        logic [9:0]         out_col;
        logic               last_of_frame;
    } out_item_t;

    typedef struct packed {
        logic             accept;
        logic             issue;
        logic             first;
        logic             last;
        logic             load;
        logic [SUB_W-1:0] sub_step;
        logic [WIN_W-1:0] win_row;
        logic [WIN_W-1:0] win_col;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_result;
        logic range_empty;
        logic out_free;
    } ctl_status_t;

endpackage

// ===== rtl/ssdm_datapath.sv =====
// ----------------------------------------------------------------------------
// ssdm_datapath
// Line stores, position counters, window address generation, sub-pixel
// interpolation, SAD accumulation and best-match tracking.
// ----------------------------------------------------------------------------
module ssdm_datapath #(
    parameter int MAX_WIDTH = 1024,
    parameter int XW        = $clog2(MAX_WIDTH) + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [10:0]           cfg_wdata,
    input  ssdm_pkg::in_item_t    in_item,
    input  ssdm_pkg::ctl_cmd_t    cmd,
    input  logic [XW-1:0]         cand_col,
    output ssdm_pkg::ctl_status_t status,
    output logic [XW-1:0]         range_lo,
    output logic [XW-1:0]         range_hi,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ssdm_pkg::out_item_t   m_item
);

    localparam int DEPTH = ssdm_pkg::RING_ROWS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int M     = ssdm_pkg::MARGIN;

    // configuration
    logic [10:0]       cfg_w_reg, cfg_h_reg;
    logic signed [7:0] cfg_min_reg;
    logic signed [8:0] cfg_max_reg;

    // position counters
    logic [ssdm_pkg::ROW_W-1:0]  row_reg;
    logic [XW-1:0]               col_reg;
    logic [ssdm_pkg::SLOT_W-1:0] slot_reg;

    // job held while searching
    logic [XW-1:0]               job_j_reg, job_lo_reg, job_hi_reg;
    logic [ssdm_pkg::SLOT_W-1:0] job_slot_reg;
    logic                        job_empty_reg;
    logic [9:0]                  job_row_reg, job_col_reg;
    logic                        job_last_reg;

    // stores
    logic [7:0] ir_mem  [DEPTH];
    logic [7:0] pat_mem [DEPTH];
    logic [7:0] ir_rd_reg, pa_rd_reg, pb_rd_reg;

    // compute stage
    logic                         s1_valid_reg, s1_first_reg, s1_last_reg;
    logic                         s1_za_reg, s1_zb_reg;
    logic [ssdm_pkg::SUB_W-1:0]   s1_s_reg;
    logic [XW-1:0]                s1_k_reg;
    logic [ssdm_pkg::ACC_W-1:0]   acc_reg;
    logic [ssdm_pkg::SAD_W-1:0]   best_sad_reg;
    logic signed [11:0]           best_d_reg;

    logic                      m_valid_reg;
    ssdm_pkg::out_item_t       out_item_reg;

    // ---- position and range at accept ----
    logic [XW-1:0]               w_eff, c_pos, c_base;
    logic [10:0]                 h_eff;
    logic [ssdm_pkg::ROW_W-1:0]  r_pos;
    logic [ssdm_pkg::SLOT_W-1:0] sl_pos;
    logic                        need;
    int                          lo_i, hi_i;
    logic [AW-1:0]               wr_addr;

    function automatic logic [AW-1:0] mem_addr(input logic [ssdm_pkg::SLOT_W-1:0] sl,
                                               input logic [XW-1:0] col);
        return AW'(int'(sl) * MAX_WIDTH) + AW'(col);
    endfunction

    always_comb begin
        if (cfg_w_reg < 11'(ssdm_pkg::WINDOW_SIZE)) begin
            w_eff = XW'(ssdm_pkg::WINDOW_SIZE);
        end else if (int'(cfg_w_reg) > MAX_WIDTH) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(cfg_w_reg);
        end
        if (cfg_h_reg < 11'(ssdm_pkg::WINDOW_SIZE)) begin
            h_eff = 11'(ssdm_pkg::WINDOW_SIZE);
        end else if (cfg_h_reg > 11'(ssdm_pkg::HEIGHT_LIMIT)) begin
            h_eff = 11'(ssdm_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = cfg_h_reg;
        end
        r_pos  = in_item.start_of_frame ? '0 : row_reg;
        c_base = in_item.start_of_frame ? '0 : col_reg;
        sl_pos = in_item.start_of_frame ? '0 : slot_reg;
        c_pos  = (c_base >= w_eff) ? w_eff - 1'b1 : c_base;
        need   = (r_pos >= ssdm_pkg::ROW_W'(ssdm_pkg::WINDOW_SIZE)) && (r_pos <= h_eff)
              && (c_pos >= XW'(M)) && (c_pos <= w_eff - XW'(M + 1));
        lo_i = int'(c_pos) + int'(cfg_min_reg);
        hi_i = int'(c_pos) + int'(cfg_max_reg);
        if (lo_i < M) begin
            lo_i = M;
        end
        if (hi_i > int'(w_eff) - M - 1) begin
            hi_i = int'(w_eff) - M - 1;
        end
        wr_addr = mem_addr(sl_pos, c_pos);
    end

    // ---- window addressing ----
    logic [ssdm_pkg::SLOT_W:0]   slot_sum;
    logic [ssdm_pkg::SLOT_W-1:0] rd_slot;
    logic [XW-1:0]               ir_col, xa, xb, xb_rd;
    logic                        za, zb;

    always_comb begin
        slot_sum = (ssdm_pkg::SLOT_W + 1)'(job_slot_reg) + (ssdm_pkg::SLOT_W + 1)'(cmd.win_row)
                 + 1'b1;
        rd_slot  = (slot_sum >= (ssdm_pkg::SLOT_W + 1)'(ssdm_pkg::RING_ROWS))
                 ? ssdm_pkg::SLOT_W'(slot_sum - (ssdm_pkg::SLOT_W + 1)'(ssdm_pkg::RING_ROWS))
                 : ssdm_pkg::SLOT_W'(slot_sum);
        ir_col = job_j_reg - XW'(M) + XW'(cmd.win_col);
        xa     = cand_col - XW'(M) + XW'(cmd.win_col);
        xb     = xa + 1'b1;
        za     = xa >= w_eff;
        zb     = xb >= w_eff;
        xb_rd  = zb ? xa : xb;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && !in_item.filler) begin
            ir_mem[wr_addr]  <= in_item.ir_pixel;
            pat_mem[wr_addr] <= in_item.pattern_pixel;
        end
        ir_rd_reg <= ir_mem[mem_addr(rd_slot, ir_col)];
        pa_rd_reg <= pat_mem[mem_addr(rd_slot, xa)];
        pb_rd_reg <= pat_mem[mem_addr(rd_slot, xb_rd)];
    end

    // ---- interpolation and SAD ----
    logic [7:0]                 a_v, b_v, sub_v, ad_v;
    logic [ssdm_pkg::SUB_W:0]   wa;
    logic [11:0]                num;
    logic [ssdm_pkg::ACC_W-1:0] acc_next;
    logic signed [11:0]         dk, d_cand;

    always_comb begin
        a_v   = s1_za_reg ? 8'd0 : pa_rd_reg;
        b_v   = s1_zb_reg ? 8'd0 : pb_rd_reg;
        wa    = (ssdm_pkg::SUB_W + 1)'(ssdm_pkg::SUBPIXEL_STEPS) - {1'b0, s1_s_reg};
        num   = 12'(wa) * 12'(a_v) + 12'(s1_s_reg) * 12'(b_v)
              + 12'(ssdm_pkg::SUBPIXEL_STEPS / 2);
        sub_v = 8'(num >> ssdm_pkg::SUB_LOG);
        ad_v  = (ir_rd_reg > sub_v) ? ir_rd_reg - sub_v : sub_v - ir_rd_reg;
        acc_next = (s1_first_reg ? '0 : acc_reg) + ssdm_pkg::ACC_W'(ad_v);
        dk     = 12'(s1_k_reg) - 12'(job_j_reg);
        d_cand = (dk <<< ssdm_pkg::SUB_LOG) + 12'(s1_s_reg);
    end

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg    <= 11'd640;
            cfg_h_reg    <= 11'd480;
            cfg_min_reg  <= -8'sd7;
            cfg_max_reg  <= 9'sd80;
            row_reg      <= '0;
            col_reg      <= '0;
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ssdm_pkg::CFG_WIDTH:    cfg_w_reg   <= cfg_wdata;
                    ssdm_pkg::CFG_HEIGHT:   cfg_h_reg   <= cfg_wdata;
                    ssdm_pkg::CFG_MIN_DISP: cfg_min_reg <= cfg_wdata[7:0];
                    ssdm_pkg::CFG_MAX_DISP: cfg_max_reg <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                if (c_pos + 1'b1 >= w_eff) begin
                    col_reg <= '0;
                    if (r_pos < ssdm_pkg::ROW_W'(ssdm_pkg::ROW_MAX)) begin
                        row_reg  <= r_pos + 1'b1;
                        slot_reg <= (sl_pos == ssdm_pkg::SLOT_W'(ssdm_pkg::RING_ROWS - 1))
                                  ? '0 : sl_pos + 1'b1;
                    end else begin
                        row_reg  <= r_pos;
                        slot_reg <= sl_pos;
                    end
                end else begin
                    col_reg  <= c_pos + 1'b1;
                    row_reg  <= r_pos;
                    slot_reg <= sl_pos;
                end
            end
            s1_valid_reg <= cmd.issue;
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            job_j_reg     <= c_pos;
            job_slot_reg  <= sl_pos;
            job_lo_reg    <= XW'(lo_i);
            job_hi_reg    <= XW'(hi_i);
            job_empty_reg <= lo_i > hi_i;
            job_row_reg   <= 10'(r_pos - ssdm_pkg::ROW_W'(ssdm_pkg::WINDOW_SIZE));
            job_col_reg   <= 10'(c_pos - XW'(M));
            job_last_reg  <= (r_pos == h_eff) && (c_pos == w_eff - XW'(M + 1));
            best_sad_reg  <= ssdm_pkg::SAD_START;
            best_d_reg    <= ssdm_pkg::NO_MATCH;
        end
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_s_reg     <= cmd.sub_step;
        s1_k_reg     <= cand_col;
        s1_za_reg    <= za;
        s1_zb_reg    <= zb;
        if (s1_valid_reg) begin
            acc_reg <= acc_next;
            // later candidate wins a tie
            if (s1_last_reg && (ssdm_pkg::SAD_W'(acc_next) <= best_sad_reg)) begin
                best_sad_reg <= ssdm_pkg::SAD_W'(acc_next);
                best_d_reg   <= d_cand;
            end
        end
        if (cmd.load) begin
            out_item_reg.disparity_eighths <= best_d_reg;
            out_item_reg.out_row           <= job_row_reg;
            out_item_reg.out_col           <= job_col_reg;
            out_item_reg.last_of_frame     <= job_last_reg;
        end
    end

    assign status.need_result = need;
    assign status.range_empty = job_empty_reg;
    assign status.out_free    = !m_valid_reg || m_ready;
    assign range_lo = job_lo_reg;
    assign range_hi = job_hi_reg;
    assign m_valid  = m_valid_reg;
    assign m_item   = out_item_reg;

endmodule

// ===== rtl/ssdm_controller.sv =====
// ----------------------------------------------------------------------------
// ssdm_controller
// Sequencer: walks sub-step, candidate column and window position per center.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssdm_controller #(
    parameter int XW = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ssdm_pkg::ctl_status_t status,
    input  logic [XW-1:0]         range_lo,
    input  logic [XW-1:0]         range_hi,
    output ssdm_pkg::ctl_cmd_t    cmd,
    output logic [XW-1:0]         cand_col
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_RUN, ST_DRAIN, ST_DELIVER
    } state_t;

    state_t                     state_reg;
    logic [ssdm_pkg::SUB_W-1:0] s_reg;
    logic [XW-1:0]              k_reg;
    logic [ssdm_pkg::WIN_W-1:0] p_reg, q_reg;

    localparam logic [ssdm_pkg::WIN_W-1:0] WIN_LAST = ssdm_pkg::WIN_W'(ssdm_pkg::WINDOW_SIZE - 1);
    localparam logic [ssdm_pkg::SUB_W-1:0] SUB_LAST =
        ssdm_pkg::SUB_W'(ssdm_pkg::SUBPIXEL_STEPS - 1);

    logic accept;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            s_reg     <= '0;
            k_reg     <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept && status.need_result) begin
                        state_reg <= ST_START;
                    end
                end
                ST_START: begin
                    s_reg <= '0;
                    k_reg <= range_lo;
                    p_reg <= '0;
                    q_reg <= '0;
                    state_reg <= status.range_empty ? ST_DELIVER : ST_RUN;
                end
                ST_RUN: begin
                    if (q_reg == WIN_LAST) begin
                        q_reg <= '0;
                        if (p_reg == WIN_LAST) begin
                            p_reg <= '0;
                            if (k_reg == range_hi) begin
                                k_reg <= range_lo;
                                if (s_reg == SUB_LAST) begin
                                    state_reg <= ST_DRAIN;
                                end else begin
                                    s_reg <= s_reg + 1'b1;
                                end
                            end else begin
                                k_reg <= k_reg + 1'b1;
                            end
                        end else begin
                            p_reg <= p_reg + 1'b1;
                        end
                    end else begin
                        q_reg <= q_reg + 1'b1;
                    end
                end
                ST_DRAIN: state_reg <= ST_DELIVER;
                ST_DELIVER: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.accept   = accept;
        cmd.issue    = (state_reg == ST_RUN);
        cmd.first    = (p_reg == '0) && (q_reg == '0);
        cmd.last     = (p_reg == WIN_LAST) && (q_reg == WIN_LAST);
        cmd.load     = (state_reg == ST_DELIVER) && status.out_free;
        cmd.sub_step = s_reg;
        cmd.win_row  = p_reg;
        cmd.win_col  = q_reg;
    end
    assign cand_col = k_reg;

    `SSDM_ASSERT(a_job_leaves_idle, (accept && status.need_result) |=> (state_reg == ST_START), "job did not start")
    `SSDM_ASSERT(a_cand_in_range, (state_reg == ST_RUN) |-> (k_reg >= range_lo && k_reg <= range_hi), "candidate out of range")
    `SSDM_ASSERT(a_load_when_free, cmd.load |-> status.out_free, "result loaded over pending output")

endmodule

// ===== rtl/subpixel_sad_disparity_matcher.sv =====
// ----------------------------------------------------------------------------
// subpixel_sad_disparity_matcher
// Sub-pixel 9x9 SAD block matcher between an IR image and a reference pattern.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one IR/pattern pixel pair per transfer in raster order;
//   start_of_frame on the first pixel, then one filler row after the frame
//   to flush the last result row.
//   m_* channel: at most one disparity (eighths of a pixel) per input item,
//   for the window center MARGIN+1 rows above the input.
//   cfg_*: plain register writes (width, height, min/max disparity); the user
//   writes only while the block is idle, the block does not enforce it.
// Search:
//   An item with no result is accepted without a search; an empty range skips
//   the search. Otherwise the block walks every sub-step, candidate column and
//   window pixel, one window pixel per cycle through the shared interpolate/
//   abs-diff unit, and takes no new item until the result is delivered.
// Reset: position counters clear, config registers take their defaults, the line
//   stores keep whatever they held (undefined until written).
// Stall: a finished result waits in the output register; the next item is
//   still accepted and searched, and delivery waits for the register.
// ----------------------------------------------------------------------------
module subpixel_sad_disparity_matcher #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [10:0]         cfg_wdata,
    // pixel input
    input  logic                s_valid,
    output logic                s_ready,
    input  ssdm_pkg::in_item_t  s_item,
    // disparity output
    output logic                m_valid,
    input  logic                m_ready,
    output ssdm_pkg::out_item_t m_item
);

    localparam int XW = $clog2(MAX_WIDTH) + 1;

    ssdm_pkg::ctl_cmd_t    cmd;
    ssdm_pkg::ctl_status_t status;
    logic [XW-1:0]         range_lo, range_hi, cand_col;

    // sequencer: owns the handshake on the input side and the search loops
    ssdm_controller #(
        .XW(XW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .status   (status),
        .range_lo (range_lo),
        .range_hi (range_hi),
        .cmd      (cmd),
        .cand_col (cand_col)
    );

    // stores, counters, SAD unit and output register
    ssdm_datapath #(
        .MAX_WIDTH(MAX_WIDTH),
        .XW       (XW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_item   (s_item),
        .cmd       (cmd),
        .cand_col  (cand_col),
        .status    (status),
        .range_lo  (range_lo),
        .range_hi  (range_hi),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
